FILE: rtl/gbr_pkg.sv
package gbr_pkg;

    localparam int MAX_GROUP_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int VALUE_W = 32;
    localparam int GS_W    = 5;

    localparam logic [GS_W-1:0] GS_RESET = GS_W'(2);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               stream_end;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] out_value;
        logic               run_last;
        logic               stream_last;
    } out_item_t;

endpackage

FILE: rtl/gbr_ram.sv
module gbr_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read register holds its word until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/group_block_reverser.sv
// channel | ports              | direction | payload
// --------+--------------------+-----------+--------------------------------------
// input   | s_valid s_ready    | in        | s_data  (value, stream_end)
// result  | m_valid m_ready    | out       | m_data  (out_value, run_last, stream_last)
// config  | cfg_valid cfg_ready| in        | cfg_data (group_size)
//
// s_ready is high whenever no burst is being read out.
// an input that closes a group or ends the stream starts a burst of n results, read from the
// buffer's read port one word a cycle while m_ready is high; s_ready stays low until it ends.
// a stalled m_ready holds the result register and pauses the burst; the result register
// may still hold the last word of a burst while the next input transfer is taken.
// reset clears the fill count and sets group size to 2; the buffer itself is not cleared.
module group_block_reverser #(
    parameter int MAX_GROUP  = gbr_pkg::MAX_GROUP_DEF,
    parameter int DATA_WIDTH = gbr_pkg::DATA_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  gbr_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output gbr_pkg::out_item_t         m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [gbr_pkg::GS_W-1:0]   cfg_data
);

    import gbr_pkg::*;

    localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int MIN_W  = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [GS_W-1:0]   group_size_reg;
    logic [CNT_W-1:0]  fill_count_reg, fill_count_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              rev_reg, rev_next;
    logic              end_reg, end_next;
    logic              m_valid_reg, m_valid_next;
    logic              run_last_reg, stream_last_reg;

    logic [CNT_W-1:0]      k_eff;
    logic [ADDR_W-1:0]     wr_idx;
    logic [CNT_W-1:0]      n_fill;
    logic                  in_xfer;
    logic                  rd_issue;
    logic                  full_group;
    logic [DATA_WIDTH-1:0] wr_word;
    logic [DATA_WIDTH-1:0] rd_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= GS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            group_size_reg <= cfg_data;
        end
    end

    // zero acts as one, anything above the buffer depth saturates
    always_comb begin
        if (group_size_reg == '0) begin
            k_eff = CNT_W'(1);
        end else if (group_size_reg > MAX_GROUP) begin
            k_eff = CNT_W'(MAX_GROUP);
        end else begin
            k_eff = CNT_W'(group_size_reg);
        end
    end

    assign wr_idx = (fill_count_reg >= CNT_W'(MAX_GROUP)) ? '0 : fill_count_reg[ADDR_W-1:0];
    assign n_fill = CNT_W'(wr_idx) + CNT_W'(1);

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_xfer    = s_valid && s_ready;
    assign full_group = (n_fill >= k_eff);
    // writes happen only in idle, reads only in emit: the two never touch one entry at once
    assign rd_issue   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        wr_word            = '0;
        wr_word[MIN_W-1:0] = s_data.value[MIN_W-1:0];
    end

    always_comb begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        rem_next        = rem_reg;
        addr_next       = addr_reg;
        rev_next        = rev_reg;
        end_next        = end_reg;
        m_valid_next    = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (full_group || s_data.stream_end) begin
                        state_next      = ST_EMIT;
                        fill_count_next = '0;
                        rem_next        = n_fill;
                        rev_next        = full_group;
                        addr_next       = full_group ? wr_idx : '0;
                        end_next        = s_data.stream_end;
                    end else begin
                        fill_count_next = n_fill;
                    end
                end
            end
            ST_EMIT: begin
                if (rd_issue) begin
                    m_valid_next = 1'b1;
                    rem_next     = rem_reg - CNT_W'(1);
                    addr_next    = rev_reg ? addr_reg - ADDR_W'(1) : addr_reg + ADDR_W'(1);
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            rem_reg        <= '0;
            addr_reg       <= '0;
            rev_reg        <= 1'b0;
            end_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            rem_reg        <= rem_next;
            addr_reg       <= addr_next;
            rev_reg        <= rev_next;
            end_reg        <= end_next;
            m_valid_reg    <= m_valid_next;
            // tags ride along with the buffer read register
            if (rd_issue) begin
                run_last_reg    <= (rem_reg == CNT_W'(1));
                stream_last_reg <= (rem_reg == CNT_W'(1)) && end_reg;
            end
        end
    end

    gbr_ram #(
        .DEPTH  (MAX_GROUP),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_buffer (
        .aclk  (aclk),
        .we    (in_xfer),
        .waddr (wr_idx),
        .wdata (wr_word),
        .re    (rd_issue),
        .raddr (addr_reg),
        .rdata (rd_word)
    );

    always_comb begin
        m_data                      = '0;
        m_data.out_value[MIN_W-1:0] = rd_word[MIN_W-1:0];
        m_data.run_last             = run_last_reg;
        m_data.stream_last          = stream_last_reg;
    end

    assign m_valid = m_valid_reg;

    ap_burst_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (rem_reg != '0))
        else $error("burst active with no words left");

    ap_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg < CNT_W'(MAX_GROUP))
        else $error("fill count reached buffer depth");

    ap_burst_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (full_group || s_data.stream_end))
        |=> (state_reg == ST_EMIT) && (fill_count_reg == '0))
        else $error("closing transfer did not start a burst");

    ap_stream_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.stream_last) |-> m_data.run_last)
        else $error("stream end tag without run end tag");

    ap_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> !$past(rd_issue) || $past(state_reg) != ST_EMIT)
        else $error("buffer read overwrote a stalled result");

endmodule

FILE: test/gbr_result_checker.sv
module gbr_result_checker
    import gbr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [GS_W-1:0]   cfg_data,
    input  logic              run_done,
    output int unsigned       error_count,
    output int unsigned       words_pending,
    output int unsigned       words_seen,
    output int unsigned       groups_reversed,
    output int unsigned       tails_flushed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [VALUE_W-1:0] held_values [MAX_GROUP_DEF];
    int unsigned        fill;
    int unsigned        span;
    int unsigned        i;
    logic [GS_W-1:0]    span_reg;
    logic               leftovers_checked;
    out_item_t          want;
    out_item_t          expected_words [$];

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill = 0;
            span_reg = GS_RESET;
            leftovers_checked = 1'b0;
            expected_words.delete();
        end else begin
            if (s_valid && s_ready) begin
                // zero acts as one, anything past the buffer depth saturates
                span = (span_reg == 0) ? 1 :
                       (span_reg > MAX_GROUP_DEF) ? MAX_GROUP_DEF : span_reg;
                if (fill >= MAX_GROUP_DEF)
                    fill = 0;
                held_values[fill] = s_data.value;
                fill++;
                if (fill >= span || s_data.stream_end) begin
                    // full group comes out newest first, a short tail oldest first
                    for (i = 0; i < fill; i++) begin
                        want.out_value   = (fill >= span) ? held_values[fill - 1 - i]
                                                          : held_values[i];
                        want.run_last    = (i + 1 == fill);
                        want.stream_last = s_data.stream_end && (i + 1 == fill);
                        expected_words.push_back(want);
                    end
                    if (fill >= span)
                        groups_reversed++;
                    else
                        tails_flushed++;
                    fill = 0;
                end
            end

            // a size written at this edge applies from the next input transfer on
            if (cfg_valid && cfg_ready)
                span_reg = cfg_data;

            if (m_valid && m_ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $error("unexpected result transfer: out_value %h run_last %b stream_last %b",
                           m_data.out_value, m_data.run_last, m_data.stream_last);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.out_value !== want.out_value) begin
                        $error("out_value: expected %h, actual %h",
                               want.out_value, m_data.out_value);
                        error_count++;
                    end
                    if (m_data.run_last !== want.run_last) begin
                        $error("run_last: expected %b, actual %b",
                               want.run_last, m_data.run_last);
                        error_count++;
                    end
                    if (m_data.stream_last !== want.stream_last) begin
                        $error("stream_last: expected %b, actual %b",
                               want.stream_last, m_data.stream_last);
                        error_count++;
                    end
                end
            end

            if (run_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (expected_words.size() != 0) begin
                    $error("%0d expected result words never arrived", expected_words.size());
                    error_count++;
                end
            end
        end
        words_pending <= expected_words.size();
    end

endmodule

FILE: test/tb_group_block_reverser.sv
module tb_group_block_reverser;
    timeunit 1ns;
    timeprecision 1ps;
    import gbr_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          DRAIN_CYCLES = 32;
    localparam int unsigned LIMIT_NS     = 2_000_000;
    localparam int          PHASE_ITEMS  = 21;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_item_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [GS_W-1:0]   cfg_data  = '0;
    logic              run_done  = 1'b0;

    int unsigned error_count;
    int unsigned words_pending;
    int unsigned words_seen;
    int unsigned groups_reversed;
    int unsigned tails_flushed;

    int unsigned s_idle_pct   = 0;
    int unsigned m_stall_pct  = 0;
    int unsigned items_sent   = 0;
    int unsigned span_writes  = 0;
    logic [GS_W-1:0] cur_span = GS_RESET;

    always #(CLK_HALF) aclk = ~aclk;

    group_block_reverser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    gbr_result_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .run_done        (run_done),
        .error_count     (error_count),
        .words_pending   (words_pending),
        .words_seen      (words_seen),
        .groups_reversed (groups_reversed),
        .tails_flushed   (tails_flushed)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_stall_pct);
    end

    // valid stays up after a transfer only when the next item follows at once
    task automatic send_value(input logic [VALUE_W-1:0] v, input logic last);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{value: v, stream_end: last};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // drop valid, wait for every expected word, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_span(input logic [GS_W-1:0] span);
        cfg_valid <= 1'b1;
        cfg_data  <= span;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_span = span;
        span_writes++;
    endtask

    function automatic logic [GS_W-1:0] pick_span();
        case ($urandom_range(7))
            0:       return '0;
            1:       return GS_W'(1);
            2:       return GS_W'(MAX_GROUP_DEF);
            3:       return '1;
            4:       return GS_W'($urandom_range(30, MAX_GROUP_DEF + 1));
            default: return GS_W'($urandom_range(MAX_GROUP_DEF - 1, 2));
        endcase
    endfunction

    task automatic random_streams(input int unsigned quota);
        int unsigned sent;
        int unsigned len;
        int unsigned eff;
        logic [VALUE_W-1:0] v;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(2) == 0) begin
                settle();
                write_span(pick_span());
            end
            eff = (cur_span == 0) ? 1 : (cur_span > MAX_GROUP_DEF) ? MAX_GROUP_DEF : cur_span;
            if ($urandom_range(7) == 0)
                len = $urandom_range(40, 1);
            else
                len = $urandom_range(2 * eff + 3, 1);
            // the phase quota cuts a stream short and ends it there
            for (int unsigned k = 0; k < len && sent < quota; k++) begin
                // occasional change of group size mid-stream, while the buffer may be partly filled
                if (k != 0 && k + 1 < len && $urandom_range(19) == 0) begin
                    settle();
                    write_span(pick_span());
                end
                case ($urandom_range(9))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = $urandom();
                endcase
                send_value(v, k + 1 == len || sent + 1 == quota);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #(LIMIT_NS);
        $display("group_block_reverser regression: fail");
        $finish;
    end

    initial begin
        do @(posedge aclk); while (!aresetn);

        // reset group size of two: full group, lone tail, full group at stream end
        send_value('0, 1'b0);
        send_value('1, 1'b0);
        send_value(32'h1234_5678, 1'b1);
        send_value(32'h8000_0001, 1'b0);
        send_value(32'h7fff_fffe, 1'b1);

        // zero group size behaves as one
        settle();
        write_span('0);
        send_value(32'ha5a5_a5a5, 1'b1);

        // oversized group size saturates to the buffer depth
        settle();
        write_span('1);
        for (int k = 0; k < MAX_GROUP_DEF; k++)
            send_value(32'h5a5a_5a5a ^ (32'h3 << (2 * k)), k == MAX_GROUP_DEF - 1);

        // lowering the size below the buffered count flushes it all reversed
        settle();
        write_span(GS_W'(5));
        send_value(32'h0000_0011, 1'b0);
        send_value(32'h0000_0022, 1'b0);
        send_value(32'h0000_0033, 1'b0);
        settle();
        write_span(GS_W'(2));
        send_value(32'h0000_0044, 1'b0);

        s_idle_pct = 0;  m_stall_pct = 0;
        random_streams(PHASE_ITEMS);
        s_idle_pct = 81; m_stall_pct = 0;
        random_streams(PHASE_ITEMS);
        s_idle_pct = 0;  m_stall_pct = 81;
        random_streams(PHASE_ITEMS);
        s_idle_pct = 18; m_stall_pct = 18;
        random_streams(PHASE_ITEMS);

        settle();
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("covered %0d input transfers and %0d group size writes over four idling mixes",
                 items_sent, span_writes);
        $display("checked %0d result words: %0d reversed groups, %0d flushed stream tails",
                 words_seen, groups_reversed, tails_flushed);
        if (error_count == 0)
            $display("group_block_reverser regression: pass");
        else
            $display("group_block_reverser regression: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/gbr_pkg.sv
rtl/gbr_ram.sv
rtl/group_block_reverser.sv
test/gbr_result_checker.sv
test/tb_group_block_reverser.sv
